[rtl/gbia_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbia_pkg: shared definitions for the grouped bitmap id allocator
// constants, op and status codes, register indexes and sequencer states
// ----------------------------------------------------------------------------
package gbia_pkg;

  localparam int GROUP_SIZE = 32;
  localparam int MAX_BLOCKS = 64;

  localparam int ID_W   = 20;
  localparam int BC_W   = 7;
  localparam int IC_W   = 12;
  localparam int OP_W   = 3;
  localparam int STS_W  = 2;
  localparam int BIT_W  = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CFG_IDX_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC_ONE  = 3'd0,
    OP_ALLOC_GRP  = 3'd1,
    OP_CLAIM      = 3'd2,
    OP_FREE_ONE   = 3'd3,
    OP_FREE_GRP   = 3'd4
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 2'd0,
    STS_NO_SPACE = 2'd1,
    STS_IN_USE   = 2'd2,
    STS_RANGE    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ID_BASE     = 2'd0,
    CFG_BLOCK_COUNT = 2'd1,
    CFG_ID_COUNT    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_EVAL = 2'd2,
    S_RESP = 2'd3
  } state_t;

endpackage

[rtl/gbia_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbia_ram: generic single-write, single-read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module gbia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/grouped_bitmap_id_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_bitmap_id_allocator_core: bitmap id allocator with group blocks
// Free map of blocks held in a ram, one block word per entry, set bit = free.
//
// Channels: requests (in_op, in_id) enter on in_valid/in_stall, results
// (out_status, out_result_id) leave on out_valid/out_stall. A beat moves at
// an edge with valid high and stall low. Registers are written through the
// cfg port (cfg_index, cfg_data), which is always ready; writes belong
// between requests, while no request is open.
//
// One request at a time. A request rejected on its id or op goes from
// acceptance straight to S_RESP. Claims and frees pass through S_READ (ram
// read), S_EVAL (read-modify-write) and S_RESP, which loads the output
// register. Allocations scan one block word per cycle starting at the hint
// block, visiting at most MAX_BLOCKS block words.
// The next request is accepted once the result is in the output register.
//
// Reset marks every ram entry as never written, which reads as all free;
// no clearing pass is needed. If the receiver stalls, the result holds in
// the output register and the block can still accept and work one more
// request, waiting to deliver it until the register empties.
// ----------------------------------------------------------------------------
module grouped_bitmap_id_allocator_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [gbia_pkg::OP_W-1:0]            in_op,
  input  logic [gbia_pkg::ID_W-1:0]            in_id,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [gbia_pkg::STS_W-1:0]           out_status,
  output logic [gbia_pkg::ID_W-1:0]            out_result_id,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gbia_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gbia_pkg::ID_W-1:0]            cfg_data
);

  localparam int GS    = gbia_pkg::GROUP_SIZE;
  localparam int MB    = gbia_pkg::MAX_BLOCKS;
  localparam int BIT_W = gbia_pkg::BIT_W;
  localparam int IDX_W = gbia_pkg::IDX_W;
  localparam int CNT_W = gbia_pkg::CNT_W;
  localparam int ID_W  = gbia_pkg::ID_W;
  localparam logic [GS-1:0] FULL = {GS{1'b1}};

  function automatic logic [BIT_W-1:0] lowest_set(input logic [GS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = GS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

  // config registers
  logic [ID_W-1:0]            id_base_r;
  logic [gbia_pkg::BC_W-1:0]  block_count_r;
  logic [gbia_pkg::IC_W-1:0]  id_count_r;

  // sequencer state
  gbia_pkg::state_t           state_r, state_nxt;
  gbia_pkg::op_t              op_r, op_nxt;
  logic [IDX_W-1:0]           blk_r, blk_nxt;
  logic [BIT_W-1:0]           bit_r, bit_nxt;
  logic [ID_W-1:0]            id_r, id_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic                       grp_r, grp_nxt;
  gbia_pkg::status_t          sts_r, sts_nxt;
  logic [ID_W-1:0]            rid_r, rid_nxt;
  logic [MB-1:0]              vld_r;

  logic                       out_valid_r;
  gbia_pkg::status_t          out_status_r;
  logic [ID_W-1:0]            out_rid_r;

  // ram ports
  logic                       ram_we, ram_re;
  logic [IDX_W-1:0]           ram_waddr, ram_raddr;
  logic [GS-1:0]              ram_wdata, ram_rdata;

  // request decode
  logic [CNT_W-1:0]           cnt;
  logic [ID_W-1:0]            off;
  logic                       req_bad;
  logic                       in_beat;
  logic                       out_free;

  // evaluation of one block word
  logic [GS-1:0]              word, masked, hint_mask, bit_oh;
  logic                       any_free, last_blk, cand, fits;
  logic [BIT_W-1:0]           low_bit;
  logic                       ev_done, ev_cont, ev_we;
  logic [GS-1:0]              ev_wdata;
  gbia_pkg::status_t          ev_sts;
  logic [ID_W-1:0]            ev_rid;

  gbia_ram #(
    .WIDTH (GS),
    .DEPTH (MB)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt = (32'(block_count_r) > 32'(MB)) ? CNT_W'(MB) : CNT_W'(block_count_r);
  assign off = in_id - id_base_r;
  assign req_bad = (32'(in_op) > 32'(gbia_pkg::OP_FREE_GRP)) || (in_id < id_base_r) ||
                   (32'(off >> BIT_W) >= 32'(cnt));
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // block word evaluation
  always_comb begin
    word      = vld_r[idx_r] ? ram_rdata : FULL;
    hint_mask = FULL << bit_r;
    bit_oh    = GS'(1) << bit_r;
    masked    = (idx_r == blk_r) ? (word & hint_mask) : word;
    any_free  = masked != '0;
    low_bit   = lowest_set(masked);
    last_blk  = (32'(idx_r) + 32'd1) >= 32'(cnt);
    cand      = grp_r || any_free;
    fits      = ((32'(idx_r) + 32'd1) << BIT_W) <= 32'(id_count_r);
    ev_done   = 1'b0;
    ev_cont   = 1'b0;
    ev_we     = 1'b0;
    ev_wdata  = word;
    ev_sts    = gbia_pkg::STS_OK;
    ev_rid    = '0;
    grp_nxt   = grp_r;
    case (op_r)
      gbia_pkg::OP_CLAIM: begin
        ev_done = 1'b1;
        if ((word & bit_oh) != '0) begin
          ev_we    = 1'b1;
          ev_wdata = word & ~bit_oh;
          ev_rid   = id_r;
        end else begin
          ev_sts = gbia_pkg::STS_IN_USE;
        end
      end
      gbia_pkg::OP_FREE_ONE: begin
        ev_done  = 1'b1;
        ev_we    = 1'b1;
        ev_wdata = word | bit_oh;
      end
      gbia_pkg::OP_FREE_GRP: begin
        ev_done  = 1'b1;
        ev_we    = 1'b1;
        ev_wdata = FULL;
      end
      gbia_pkg::OP_ALLOC_ONE: begin
        if (any_free) begin
          ev_done  = 1'b1;
          ev_we    = 1'b1;
          ev_wdata = word & ~(GS'(1) << low_bit);
          ev_rid   = id_base_r + ID_W'({idx_r, low_bit});
        end else if (last_blk) begin
          ev_done = 1'b1;
          ev_sts  = gbia_pkg::STS_NO_SPACE;
        end else begin
          ev_cont = 1'b1;
        end
      end
      gbia_pkg::OP_ALLOC_GRP: begin
        if (cand && word == FULL) begin
          ev_done = 1'b1;
          if (fits) begin
            ev_we    = 1'b1;
            ev_wdata = '0;
            ev_rid   = id_base_r + ID_W'({idx_r, BIT_W'(0)});
          end else begin
            ev_sts = gbia_pkg::STS_NO_SPACE;
          end
        end else if (last_blk) begin
          ev_done = 1'b1;
          ev_sts  = gbia_pkg::STS_NO_SPACE;
        end else begin
          ev_cont = 1'b1;
          grp_nxt = cand;
        end
      end
      default: begin
        ev_done = 1'b1;
        ev_sts  = gbia_pkg::STS_RANGE;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gbia_pkg::S_IDLE: begin
        if (in_beat) begin
          state_nxt = req_bad ? gbia_pkg::S_RESP : gbia_pkg::S_READ;
        end
      end
      gbia_pkg::S_READ: begin
        state_nxt = gbia_pkg::S_EVAL;
      end
      gbia_pkg::S_EVAL: begin
        if (ev_done) begin
          state_nxt = gbia_pkg::S_RESP;
        end
      end
      gbia_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = gbia_pkg::S_IDLE;
        end
      end
      default: state_nxt = gbia_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    in_stall  = 1'b1;
    ram_re    = 1'b0;
    ram_raddr = idx_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ev_wdata;
    op_nxt    = op_r;
    blk_nxt   = blk_r;
    bit_nxt   = bit_r;
    id_nxt    = id_r;
    idx_nxt   = idx_r;
    sts_nxt   = sts_r;
    rid_nxt   = rid_r;
    unique case (state_r)
      gbia_pkg::S_IDLE: begin
        in_stall = 1'b0;
        op_nxt   = gbia_pkg::op_t'(in_op);
        blk_nxt  = IDX_W'(off >> BIT_W);
        bit_nxt  = off[BIT_W-1:0];
        id_nxt   = in_id;
        idx_nxt  = IDX_W'(off >> BIT_W);
        sts_nxt  = gbia_pkg::STS_RANGE;
        rid_nxt  = '0;
      end
      gbia_pkg::S_READ: begin
        ram_re = 1'b1;
      end
      gbia_pkg::S_EVAL: begin
        ram_we  = ev_we;
        sts_nxt = ev_sts;
        rid_nxt = ev_rid;
        if (ev_cont) begin
          idx_nxt   = idx_r + IDX_W'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_r + IDX_W'(1);
        end
      end
      gbia_pkg::S_RESP: begin
        in_stall = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= gbia_pkg::S_IDLE;
      vld_r         <= '0;
      out_valid_r   <= 1'b0;
      grp_r         <= 1'b0;
      id_base_r     <= '0;
      block_count_r <= gbia_pkg::BC_W'(64);
      id_count_r    <= gbia_pkg::IC_W'(2048);
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (gbia_pkg::cfg_idx_t'(cfg_index))
          gbia_pkg::CFG_ID_BASE:     id_base_r     <= cfg_data;
          gbia_pkg::CFG_BLOCK_COUNT: block_count_r <= cfg_data[gbia_pkg::BC_W-1:0];
          gbia_pkg::CFG_ID_COUNT:    id_count_r    <= cfg_data[gbia_pkg::IC_W-1:0];
          default: ;
        endcase
      end
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      if (state_r == gbia_pkg::S_IDLE) begin
        grp_r <= 1'b0;
      end else if (state_r == gbia_pkg::S_EVAL) begin
        grp_r <= grp_nxt;
      end
      if (state_r == gbia_pkg::S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    blk_r <= blk_nxt;
    bit_r <= bit_nxt;
    id_r  <= id_nxt;
    idx_r <= idx_nxt;
    sts_r <= sts_nxt;
    rid_r <= rid_nxt;
    if (state_r == gbia_pkg::S_RESP && out_free) begin
      out_status_r <= sts_r;
      out_rid_r    <= (sts_r == gbia_pkg::STS_OK) ? rid_r : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_result_id = out_rid_r;

  a_we_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == gbia_pkg::S_EVAL)
    else $error("map write outside evaluation");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> state_r != gbia_pkg::S_IDLE)
    else $error("accepted request did not start");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gbia_pkg::S_EVAL |-> 32'(idx_r) < 32'(cnt))
    else $error("scan index beyond block count");

  a_fail_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != gbia_pkg::STS_OK |-> out_rid_r == '0)
    else $error("failed result carries an id");

  a_result_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == gbia_pkg::S_RESP)
    else $error("result without response step");

endmodule

[tb/id_alloc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_alloc_checker: result predictor and comparator for the id allocator
// Watches the request, result and register channels. Keeps its own copy of
// the free map and the registers, works out the status and id that every
// accepted request must return, and compares each result beat in order.
// ----------------------------------------------------------------------------
module id_alloc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [gbia_pkg::OP_W-1:0]      in_op,
  input  logic [gbia_pkg::ID_W-1:0]      in_id,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [gbia_pkg::STS_W-1:0]     out_status,
  input  logic [gbia_pkg::ID_W-1:0]      out_result_id,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [gbia_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbia_pkg::ID_W-1:0]      cfg_data,
  output int unsigned                    mismatches,
  output int unsigned                    in_flight
);

  localparam int GS   = gbia_pkg::GROUP_SIZE;
  localparam int MB   = gbia_pkg::MAX_BLOCKS;
  localparam int ID_W = gbia_pkg::ID_W;

  typedef struct packed {
    gbia_pkg::status_t status;
    logic [ID_W-1:0]   rid;
  } grant_t;

  logic [GS-1:0]                   shadow_map [MB];
  logic [ID_W-1:0]                 base_cfg;
  logic [gbia_pkg::BC_W-1:0]       blocks_cfg;
  logic [gbia_pkg::IC_W-1:0]       ids_cfg;
  grant_t                          awaiting_grants [$];
  int unsigned                     fail_tally = 0;

  function automatic grant_t resolve_request(input logic [gbia_pkg::OP_W-1:0] op,
                                             input logic [ID_W-1:0] id);
    grant_t        g;
    int unsigned   live;
    int unsigned   off;
    int unsigned   blk;
    int unsigned   bit_pos;
    int unsigned   i;
    int unsigned   b;
    logic [GS-1:0] reach;
    g.status = gbia_pkg::STS_RANGE;
    g.rid    = '0;
    live = (blocks_cfg > MB) ? MB : blocks_cfg;
    if (op > gbia_pkg::OP_FREE_GRP || id < base_cfg) return g;
    off     = id - base_cfg;
    blk     = off / GS;
    bit_pos = off % GS;
    if (blk >= live) return g;
    case (op)
      gbia_pkg::OP_ALLOC_ONE, gbia_pkg::OP_ALLOC_GRP: begin
        // hint block counts only from the hint bit upward
        reach = {GS{1'b1}} << bit_pos;
        i = blk;
        while (i < live && ((i == blk) ? (shadow_map[i] & reach) == '0
                                       : shadow_map[i] == '0))
          i++;
        g.status = gbia_pkg::STS_NO_SPACE;
        if (i < live && op == gbia_pkg::OP_ALLOC_ONE) begin
          b = (i == blk) ? bit_pos : 0;
          while (b < GS && !shadow_map[i][b]) b++;
          if (b < GS) begin
            shadow_map[i][b] = 1'b0;
            g.rid    = base_cfg + ID_W'(i * GS + b);
            g.status = gbia_pkg::STS_OK;
          end
        end else if (i < live) begin
          while (i < live && shadow_map[i] != {GS{1'b1}}) i++;
          if (i < live && (i + 1) * GS <= ids_cfg) begin
            shadow_map[i] = '0;
            g.rid    = base_cfg + ID_W'(i * GS);
            g.status = gbia_pkg::STS_OK;
          end
        end
      end
      gbia_pkg::OP_CLAIM: begin
        if (!shadow_map[blk][bit_pos]) begin
          g.status = gbia_pkg::STS_IN_USE;
        end else begin
          shadow_map[blk][bit_pos] = 1'b0;
          g.rid    = id;
          g.status = gbia_pkg::STS_OK;
        end
      end
      gbia_pkg::OP_FREE_ONE: begin
        shadow_map[blk][bit_pos] = 1'b1;
        g.status = gbia_pkg::STS_OK;
      end
      default: begin
        shadow_map[blk] = {GS{1'b1}};
        g.status = gbia_pkg::STS_OK;
      end
    endcase
    return g;
  endfunction

  always @(posedge clk) begin : monitor
    grant_t want;
    if (!rst_n) begin
      for (int k = 0; k < MB; k++) shadow_map[k] = {GS{1'b1}};
      base_cfg   = '0;
      blocks_cfg = gbia_pkg::BC_W'(MB);
      ids_cfg    = gbia_pkg::IC_W'(2048);
      awaiting_grants.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (gbia_pkg::cfg_idx_t'(cfg_index))
          gbia_pkg::CFG_ID_BASE:     base_cfg   = cfg_data;
          gbia_pkg::CFG_BLOCK_COUNT: blocks_cfg = cfg_data[gbia_pkg::BC_W-1:0];
          gbia_pkg::CFG_ID_COUNT:    ids_cfg    = cfg_data[gbia_pkg::IC_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        awaiting_grants.push_back(resolve_request(in_op, in_id));
      if (out_valid && !out_stall) begin
        if (awaiting_grants.size() == 0) begin
          $error("result beat with nothing expected: status %0d id 0x%05h",
                 out_status, out_result_id);
          fail_tally++;
        end else begin
          want = awaiting_grants.pop_front();
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            fail_tally++;
          end
          if (out_result_id !== want.rid) begin
            $error("out_result_id: expected 0x%05h, got 0x%05h", want.rid,
                   out_result_id);
            fail_tally++;
          end
        end
      end
    end
    mismatches <= fail_tally;
    in_flight  <= awaiting_grants.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: request stimulus and verdict for the grouped bitmap id allocator
// Runs a short directed sequence at reset settings, then phases of random
// alloc, claim and free traffic under several register settings, with
// random request gaps and result stalls except in the calm phase.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int OP_W      = gbia_pkg::OP_W;
  localparam int ID_W      = gbia_pkg::ID_W;
  localparam int STS_W     = gbia_pkg::STS_W;
  localparam int CFG_IDX_W = gbia_pkg::CFG_IDX_W;
  localparam int GS        = gbia_pkg::GROUP_SIZE;
  localparam int MB        = gbia_pkg::MAX_BLOCKS;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned BUSY_PCT    = 22;

  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op      = '0;
  logic [ID_W-1:0]      in_id      = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [STS_W-1:0]     out_status;
  logic [ID_W-1:0]      out_result_id;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [ID_W-1:0]      cfg_data   = '0;

  int unsigned mismatches;
  int unsigned in_flight;
  int unsigned jitter_pct  = BUSY_PCT;
  int unsigned cycle_count = 0;

  grouped_bitmap_id_allocator_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_id         (in_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_result_id (out_result_id),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  id_alloc_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_id         (in_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_result_id (out_result_id),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .in_flight     (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < jitter_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    while ($urandom_range(0, 99) < jitter_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_id    <= id;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait until every result beat is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  task automatic write_reg(input gbia_pkg::cfg_idx_t idx, input logic [ID_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic logic [OP_W-1:0] OP_OP_NOISE();
    return OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 34) return gbia_pkg::OP_ALLOC_ONE;
    if (r < 46) return gbia_pkg::OP_ALLOC_GRP;
    if (r < 60) return gbia_pkg::OP_CLAIM;
    if (r < 82) return gbia_pkg::OP_FREE_ONE;
    if (r < 93) return gbia_pkg::OP_FREE_GRP;
    return OP_OP_NOISE();
  endfunction

  function automatic logic [ID_W-1:0] pick_id(input logic [ID_W-1:0] base,
                                              input int unsigned live);
    int unsigned r;
    int unsigned span;
    r    = $urandom_range(0, 99);
    span = (live == 0) ? GS : live * GS;
    if (r < 80) return base + ID_W'($urandom_range(0, span - 1));
    if (r < 87) return base + ID_W'(span + $urandom_range(0, 63));
    if (r < 93) return base - ID_W'($urandom_range(1, 64));
    return ID_W'($urandom());
  endfunction

  task automatic run_phase(input logic [ID_W-1:0] base, input int unsigned blocks,
                           input int unsigned ids, input int unsigned beats,
                           input bit calm);
    int unsigned live;
    write_reg(gbia_pkg::CFG_ID_BASE, base);
    write_reg(gbia_pkg::CFG_BLOCK_COUNT, ID_W'(blocks));
    write_reg(gbia_pkg::CFG_ID_COUNT, ID_W'(ids));
    cfg_valid <= 1'b0;
    live = (blocks > MB) ? MB : blocks;
    jitter_pct = calm ? 0 : BUSY_PCT;
    repeat (beats) send(pick_op(), pick_id(base, live));
    drain();
    jitter_pct = BUSY_PCT;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed sequence at reset settings
    send(gbia_pkg::OP_ALLOC_ONE, 20'd0);
    send(gbia_pkg::OP_ALLOC_ONE, 20'd0);
    send(gbia_pkg::OP_ALLOC_ONE, 20'd31);
    send(gbia_pkg::OP_ALLOC_ONE, 20'd31);
    send(gbia_pkg::OP_ALLOC_GRP, 20'd0);
    send(gbia_pkg::OP_CLAIM, 20'd5);
    send(gbia_pkg::OP_CLAIM, 20'd5);
    send(gbia_pkg::OP_CLAIM, 20'd2047);
    send(gbia_pkg::OP_FREE_ONE, 20'd5);
    send(gbia_pkg::OP_FREE_GRP, 20'd64);
    send(gbia_pkg::OP_ALLOC_GRP, 20'd2047);
    send(gbia_pkg::OP_ALLOC_ONE, 20'd2047);
    send(OP_UNDEF_LO, 20'd0);
    send(OP_UNDEF_HI, 20'hFFFFF);
    send(gbia_pkg::OP_CLAIM, 20'd2048);
    send(gbia_pkg::OP_FREE_ONE, 20'hFFFFF);
    send(gbia_pkg::OP_FREE_GRP, 20'd4000);
    send(gbia_pkg::OP_FREE_GRP, 20'd0);
    send(gbia_pkg::OP_FREE_ONE, 20'd2047);
    send(gbia_pkg::OP_FREE_GRP, 20'd32);
    drain();

    run_phase(20'h00000, 4, 2048, 300, 1'b0);
    run_phase(20'hFFFF0, 4, 4095, 250, 1'b0);
    run_phase(20'h12345, 2, 50, 250, 1'b0);
    run_phase(20'h00000, 1, 1, 150, 1'b0);
    run_phase(20'h00400, 8, 200, 300, 1'b1);
    run_phase(20'h00000, 0, 2048, 40, 1'b0);
    run_phase(20'hABCDE, 100, 4095, 200, 1'b0);
    run_phase(20'h00000, 64, 2048, 300, 1'b0);
    run_phase(20'hFFFFF, 64, 2048, 60, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/gbia_pkg.sv
rtl/gbia_ram.sv
rtl/grouped_bitmap_id_allocator_core.sv
tb/id_alloc_checker.sv
tb/tb_top.sv
